@@ rtl/crt_pkg.sv @@
`timescale 1ns / 1ps
package crt_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam logic [1:0] FUNC_SEND   = 2'd0;
  localparam logic [1:0] FUNC_ACK    = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_RETX   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  localparam logic [2:0] ST_IN_PROGRESS = 3'd0;
  localparam logic [2:0] ST_SUCCESS     = 3'd1;
  localparam logic [2:0] ST_FAILED      = 3'd2;
  localparam logic [2:0] ST_TIMEOUT     = 3'd3;
  localparam logic [2:0] ST_DENIED      = 3'd4;
  localparam logic [2:0] ST_FULL        = 3'd5;

  localparam logic [7:0] RES_ACCEPTED    = 8'd0;
  localparam logic [7:0] RES_DENIED      = 8'd2;
  localparam logic [7:0] RES_IN_PROGRESS = 8'd5;

  localparam logic [7:0] DONE_PROGRESS = 8'd100;

  localparam logic [1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_TGT_SYS   = 2'd1;
  localparam logic [1:0] REG_TGT_COMP  = 2'd2;

  typedef struct packed {
    logic        retry_cat;
    logic [15:0] seq;
    logic [15:0] cmd;
    logic [7:0]  retries;
    logic [7:0]  confirm;
    logic [15:0] age;
    logic [15:0] target;
    logic [63:0] pa;
    logic [63:0] pb;
    logic [63:0] pc;
    logic [31:0] pd;
  } pay_t;

  typedef struct packed {
    logic valid;
    logic pend;
    pay_t pay;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic age;
  } cell_ctl_t;

endpackage

@@ rtl/crt_cell.sv @@
`timescale 1ns / 1ps
module crt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  crt_pkg::cell_ctl_t ctl,
  input  crt_pkg::entry_t   shift_in,
  input  crt_pkg::entry_t   load_in,
  input  logic [15:0]       timeout,
  output crt_pkg::entry_t   ent
);

  logic          valid_r, valid_nxt;
  logic          pend_r, pend_nxt;
  crt_pkg::pay_t pay_r, pay_nxt;

  always_comb begin
    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    pay_nxt   = pay_r;
    if (ctl.load) begin
      valid_nxt = load_in.valid;
      pend_nxt  = load_in.pend;
      pay_nxt   = load_in.pay;
    end else if (ctl.shift) begin
      valid_nxt = shift_in.valid;
      pend_nxt  = shift_in.pend;
      pay_nxt   = shift_in.pay;
    end else if (ctl.age) begin
      pend_nxt = 1'b0;
      if (valid_r) begin
        // age saturates
        if (pay_r.age != 16'hFFFF) pay_nxt.age = pay_r.age + 16'd1;
        pend_nxt          = (pay_nxt.age > timeout);
        pay_nxt.retry_cat = (pay_r.retries != 8'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
  end

  assign ent.valid = valid_r;
  assign ent.pend  = pend_r;
  assign ent.pay   = pay_r;

endmodule

@@ rtl/command_retry_tracker.sv @@
`timescale 1ns / 1ps
// Send: the result is strobed the next cycle. Entries sit in a ring of cells that rotates
// one place per cycle while scanning; ack and tick work in full turns of the ring per pass.
// Ack: one pass selects the matching entry, a second acts on it if one was found.
// Tick: one action per pass, retransmissions before timeouts. One item at a time while
// busy is high; results are strobed one cycle each and the receiver cannot stall.
// Reset (synchronous, rst_n low): table empty, sequence 0, timeout 1000, target 1/1.
module command_retry_tracker #(
  parameter int ENTRIES = crt_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_command_id,
  input  logic [7:0]  in_retry_limit,
  input  logic [63:0] in_params_12,
  input  logic [63:0] in_params_34,
  input  logic [63:0] in_params_56,
  input  logic [31:0] in_param_seven,
  input  logic [7:0]  in_ack_result,
  input  logic [7:0]  in_ack_progress,
  output logic        out_strobe,
  output logic [1:0]  out_kind,
  output logic [15:0] out_sequence_res,
  output logic [15:0] out_command,
  output logic [7:0]  out_confirmation,
  output logic [63:0] out_params_12,
  output logic [63:0] out_params_34,
  output logic [63:0] out_params_56,
  output logic [31:0] out_param_seven,
  output logic [15:0] out_target_address,
  output logic [2:0]  out_status,
  output logic [7:0]  out_progress,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_COUNT = 3'b010,
    S_SCAN  = 3'b100
  } state_t;

  state_t state_r;

  logic [15:0] timeout_r;
  logic [7:0]  tgt_sys_r, tgt_comp_r;
  logic [15:0] next_seq_r;

  logic             mode_ack_r;
  logic             group_retry_r;
  logic             act_valid_r;
  logic [IDX_W-1:0] act_step_r;
  logic [IDX_W-1:0] step_r;
  logic             found_r;
  logic [IDX_W-1:0] best_step_r;
  logic [15:0]      best_seq_r;
  logic [CNT_W-1:0] rem_r;
  logic [15:0]      ack_cmd_r;
  logic [7:0]       ack_res_r, ack_prog_r;

  crt_pkg::entry_t cell_q [ENTRIES];
  crt_pkg::entry_t shift_d [ENTRIES];
  crt_pkg::entry_t load_d;
  crt_pkg::entry_t head, mod_head;
  logic [ENTRIES-1:0] load_vec;

  logic accept;
  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // send slot search: matching sequence first, then first free cell
  logic             hit_found, free_found, send_full;
  logic [IDX_W-1:0] hit_idx, free_idx, slot_idx;
  logic [15:0]      tgt;
  assign tgt = {tgt_sys_r, tgt_comp_r};

  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!hit_found && cell_q[i].valid && cell_q[i].pay.seq == next_seq_r) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
      if (!free_found && !cell_q[i].valid) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
    slot_idx  = hit_found ? hit_idx : free_idx;
    send_full = !hit_found && !free_found;
  end

  logic send_acc;
  assign send_acc = accept && (in_func == crt_pkg::FUNC_SEND);

  always_comb begin
    load_d.valid         = 1'b1;
    load_d.pend          = 1'b0;
    load_d.pay.retry_cat = 1'b0;
    load_d.pay.seq       = next_seq_r;
    load_d.pay.cmd       = in_command_id;
    load_d.pay.retries   = in_retry_limit;
    load_d.pay.confirm   = 8'd0;
    load_d.pay.age       = 16'd0;
    load_d.pay.target    = tgt;
    load_d.pay.pa        = in_params_12;
    load_d.pay.pb        = in_params_34;
    load_d.pay.pc        = in_params_56;
    load_d.pay.pd        = in_param_seven;
    for (int i = 0; i < ENTRIES; i++)
      load_vec[i] = send_acc && !send_full && (slot_idx == IDX_W'(i));
  end

  // head of the ring: action on the selected entry, then selection scan
  logic       is_act;
  logic [1:0] emit_kind;
  logic [2:0] emit_status;
  logic [7:0] emit_prog;
  logic       cand, better, last_step;

  assign head      = cell_q[0];
  assign last_step = (step_r == IDX_W'(ENTRIES - 1));
  assign is_act    = (state_r == S_SCAN) && act_valid_r && (step_r == act_step_r);

  always_comb begin
    mod_head    = head;
    emit_kind   = crt_pkg::KIND_REPORT;
    emit_status = crt_pkg::ST_IN_PROGRESS;
    emit_prog   = 8'd0;
    if (is_act) begin
      if (mode_ack_r) begin
        if (ack_res_r == crt_pkg::RES_IN_PROGRESS) begin
          emit_prog = ack_prog_r;
        end else begin
          emit_prog      = crt_pkg::DONE_PROGRESS;
          mod_head.valid = 1'b0;
          if (ack_res_r == crt_pkg::RES_ACCEPTED)    emit_status = crt_pkg::ST_SUCCESS;
          else if (ack_res_r == crt_pkg::RES_DENIED) emit_status = crt_pkg::ST_DENIED;
          else                                       emit_status = crt_pkg::ST_FAILED;
        end
      end else if (group_retry_r) begin
        emit_kind            = crt_pkg::KIND_RETX;
        mod_head.pend        = 1'b0;
        mod_head.pay.retries = head.pay.retries - 8'd1;
        mod_head.pay.age     = 16'd0;
        mod_head.pay.confirm = head.pay.confirm + 8'd1;
      end else begin
        emit_status    = crt_pkg::ST_TIMEOUT;
        mod_head.valid = 1'b0;
      end
    end
    if (mode_ack_r)
      cand = mod_head.valid && (mod_head.pay.cmd == ack_cmd_r);
    else
      cand = mod_head.valid && mod_head.pend && (mod_head.pay.retry_cat == group_retry_r);
    better = cand && (!found_r || (mod_head.pay.seq < best_seq_r));
  end

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      crt_pkg::cell_ctl_t ctl;
      assign ctl.shift  = (state_r == S_SCAN);
      assign ctl.load   = load_vec[g];
      assign ctl.age    = accept && (in_func == crt_pkg::FUNC_TICK);
      assign shift_d[g] = (g == ENTRIES - 1) ? mod_head : cell_q[(g + 1) % ENTRIES];
      crt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .shift_in (shift_d[g]),
        .load_in  (load_d),
        .timeout  (timeout_r),
        .ent      (cell_q[g])
      );
    end
  endgenerate

  logic [CNT_W-1:0] pend_cnt;
  always_comb begin
    pend_cnt = '0;
    for (int i = 0; i < ENTRIES; i++)
      pend_cnt = pend_cnt + CNT_W'(cell_q[i].pend);
  end

  logic             found_nxt;
  logic [IDX_W-1:0] best_step_nxt;
  assign found_nxt     = found_r || better;
  assign best_step_nxt = better ? step_r : best_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      timeout_r     <= 16'd1000;
      tgt_sys_r     <= 8'd1;
      tgt_comp_r    <= 8'd1;
      next_seq_r    <= 16'd0;
      mode_ack_r    <= 1'b0;
      group_retry_r <= 1'b0;
      act_valid_r   <= 1'b0;
      step_r        <= '0;
      found_r       <= 1'b0;
      rem_r         <= '0;
      out_strobe    <= 1'b0;
    end else begin
      out_strobe <= send_acc || is_act;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          crt_pkg::REG_TIMEOUT:  timeout_r  <= cfg_data;
          crt_pkg::REG_TGT_SYS:  tgt_sys_r  <= cfg_data[7:0];
          crt_pkg::REG_TGT_COMP: tgt_comp_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (send_acc && !send_full) next_seq_r <= next_seq_r + 16'd1;
      if (is_act && !mode_ack_r) rem_r <= rem_r - CNT_W'(1);
      unique case (state_r)
        S_IDLE: begin
          act_valid_r <= 1'b0;
          found_r     <= 1'b0;
          step_r      <= '0;
          if (accept && in_func == crt_pkg::FUNC_ACK) begin
            mode_ack_r <= 1'b1;
            state_r    <= S_SCAN;
          end else if (accept && in_func == crt_pkg::FUNC_TICK) begin
            mode_ack_r    <= 1'b0;
            group_retry_r <= 1'b1;
            state_r       <= S_COUNT;
          end
        end
        S_COUNT: begin
          rem_r   <= pend_cnt;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (!last_step) begin
            step_r  <= step_r + IDX_W'(1);
            found_r <= found_nxt;
          end else begin
            step_r  <= '0;
            found_r <= 1'b0;
            if (mode_ack_r && act_valid_r) begin
              state_r <= S_IDLE;
            end else if (found_nxt) begin
              act_valid_r <= 1'b1;
              act_step_r  <= best_step_nxt;
            end else if (!mode_ack_r && group_retry_r) begin
              group_retry_r <= 1'b0;
              act_valid_r   <= 1'b0;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (better) best_seq_r <= mod_head.pay.seq;
    if (state_r == S_SCAN) best_step_r <= best_step_nxt;
    if (accept) begin
      ack_cmd_r  <= in_command_id;
      ack_res_r  <= in_ack_result;
      ack_prog_r <= in_ack_progress;
    end
    if (send_acc) begin
      out_kind           <= send_full ? crt_pkg::KIND_REPORT : crt_pkg::KIND_FIRST;
      out_sequence_res   <= next_seq_r;
      out_command        <= in_command_id;
      out_confirmation   <= 8'd0;
      out_params_12      <= in_params_12;
      out_params_34      <= in_params_34;
      out_params_56      <= in_params_56;
      out_param_seven    <= in_param_seven;
      out_target_address <= tgt;
      out_status         <= send_full ? crt_pkg::ST_FULL : crt_pkg::ST_IN_PROGRESS;
      out_progress       <= 8'd0;
      out_last           <= 1'b1;
    end else if (is_act) begin
      out_kind           <= emit_kind;
      out_sequence_res   <= mod_head.pay.seq;
      out_command        <= mod_head.pay.cmd;
      out_confirmation   <= mod_head.pay.confirm;
      out_params_12      <= mod_head.pay.pa;
      out_params_34      <= mod_head.pay.pb;
      out_params_56      <= mod_head.pay.pc;
      out_param_seven    <= mod_head.pay.pd;
      out_target_address <= mod_head.pay.target;
      out_status         <= emit_status;
      out_progress       <= emit_prog;
      out_last           <= mode_ack_r || (rem_r == CNT_W'(1));
    end
  end

  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (step_r == '0))
    else $error("ring not at home position while idle");

  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r == S_SCAN) && state_r == S_IDLE && !mode_ack_r) |-> (rem_r == '0))
    else $error("tick ended with results still owed");

  a_send_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == crt_pkg::FUNC_SEND) |=> (out_strobe && out_last))
    else $error("send did not produce its result");

  a_act_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (act_valid_r && state_r == S_SCAN && step_r == act_step_r && mode_ack_r)
      |=> (out_strobe && out_last))
    else $error("ack action without final result");

endmodule
